// ----- rtl/aenc_pkg.sv -----
// Shared types and constants for the arithmetic encoder.
// No dependencies.
package aenc_pkg;

  localparam int NUM_SYMBOLS   = 256;
  localparam int COUNT_BITS    = 16;
  localparam int ADDR_W        = $clog2(NUM_SYMBOLS);
  localparam int ENTRY_W       = 2 * COUNT_BITS;
  localparam int RANGE_W       = 33;
  localparam int DVD_W         = RANGE_W + COUNT_BITS;
  localparam int DCNT_W        = $clog2(DVD_W + 1);

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [15:0] PEND_MAX = 16'hFFFF;

  typedef struct packed {
    logic                  start;
    logic [DVD_W-1:0]      dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RANGE_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_READ   = 8'b00000010,
    S_MUL_LO = 8'b00000100,
    S_DIV_LO = 8'b00001000,
    S_MUL_HI = 8'b00010000,
    S_DIV_HI = 8'b00100000,
    S_SHIFT  = 8'b01000000,
    S_EMIT   = 8'b10000000
  } state_t;

endpackage

// ----- rtl/aenc_model_ram.sv -----
// Model table: one count pair per symbol, one write and one registered read port.
// Depends on aenc_pkg.
module aenc_model_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [aenc_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [aenc_pkg::ENTRY_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [aenc_pkg::ADDR_W-1:0]  rd_addr,
  output logic [aenc_pkg::ENTRY_W-1:0] rd_data
);
  import aenc_pkg::*;

  logic [ENTRY_W-1:0] mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/aenc_divider.sv -----
// Restoring divider, one quotient bit per cycle, for interval scaling.
// Depends on aenc_pkg.
module aenc_divider (
  input  logic               clk,
  input  logic               rst,
  input  aenc_pkg::div_req_t req,
  output aenc_pkg::div_rsp_t rsp
);
  import aenc_pkg::*;

  logic [DVD_W-1:0]      dvd;
  logic [DVD_W-1:0]      quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [DCNT_W-1:0]     cnt;
  logic                  busy;
  logic                  done;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= DCNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // bring down one dividend bit, subtract where it fits
        rem <= fits ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
        quo <= {quo[DVD_W-2:0], fits};
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo[RANGE_W-1:0];

endmodule

// ----- rtl/arithmetic_encoder_32bit.sv -----
// Arithmetic encoder top level: sequencer, interval registers, result register.
// Encode: an item that passes the symbol checks runs two 49-step restoring divisions
// on the shared divider, then up to 32 renormalisation shifts.
// One item at a time: a new item is accepted only while the sequencer is idle.
// Reset: synchronous, active high; resets the interval, clears the pending count, sets the stored total to 1.
// The model table is not cleared; entries read before being written are undefined.
module arithmetic_encoder_32bit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [7:0]                      symbol,
  input  logic [aenc_pkg::COUNT_BITS-1:0] cum_low,
  input  logic [aenc_pkg::COUNT_BITS-1:0] cum_high,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     total_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            code_bit,
  output logic [15:0]                     follow_count,
  output logic [31:0]                     final_low,
  output logic                            is_final,
  output logic                            sym_error,
  output logic                            last
);
  import aenc_pkg::*;

  state_t state;

  // configuration and interval state
  logic [15:0]        tot_cfg;
  logic [31:0]        ilow;
  logic [31:0]        ihigh;
  logic [15:0]        pend;

  // working registers for one encode
  logic [COUNT_BITS-1:0] cl;
  logic [COUNT_BITS-1:0] ch;
  logic [COUNT_BITS-1:0] tot;
  logic [RANGE_W-1:0]    range_r;
  logic [RANGE_W-1:0]    ql;
  logic                  sym_bad;
  logic                  emit_fin;
  logic [5:0]            shifts;

  // held result: last flag not known until the next shift decision
  logic        hold_valid;
  logic        hold_bit;
  logic [15:0] hold_follow;

  logic                  accept;
  logic                  slot_free;
  logic                  ram_wr;
  logic                  sym_ok;
  logic [ENTRY_W-1:0]    ram_q;
  logic [COUNT_BITS-1:0] ent_lo;
  logic [COUNT_BITS-1:0] ent_hi;
  logic [COUNT_BITS-1:0] tot_eff;
  logic [COUNT_BITS-1:0] cl_c;
  logic [COUNT_BITS-1:0] ch_c;
  logic [COUNT_BITS-1:0] mul_opd;
  div_req_t              dreq;
  div_rsp_t              drsp;
  logic [32:0]           nl;
  logic [33:0]           nh_m1;
  logic                  e12;
  logic                  e3;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign sym_ok    = {1'b0, symbol} < 9'(NUM_SYMBOLS);
  assign ram_wr    = accept && (func == FUNC_WRITE) && sym_ok;

  aenc_model_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (symbol[ADDR_W-1:0]),
    .wr_data ({cum_high, cum_low}),
    .rd_en   (accept),
    .rd_addr (symbol[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  // clamp the counts to the total; a zero total acts as one
  assign ent_lo  = ram_q[COUNT_BITS-1:0];
  assign ent_hi  = ram_q[ENTRY_W-1:COUNT_BITS];
  assign tot_eff = (tot_cfg == '0) ? COUNT_BITS'(1) : tot_cfg[COUNT_BITS-1:0];
  assign cl_c    = (ent_lo > tot_eff) ? tot_eff : ent_lo;
  assign ch_c    = (ent_hi > tot_eff) ? tot_eff : ent_hi;

  // one multiplier, shared by both bounds; the divider registers the product
  assign mul_opd       = (state == S_MUL_HI) ? ch : cl;
  assign dreq.start    = (state == S_MUL_LO) || (state == S_MUL_HI);
  assign dreq.dividend = DVD_W'(range_r) * DVD_W'(mul_opd);
  assign dreq.divisor  = tot;

  aenc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign nl    = {1'b0, ilow} + ql;
  assign nh_m1 = {2'b00, ilow} + {1'b0, drsp.quotient} - 34'd1;

  // E1/E2: top bits equal; E3: low = 01..., high = 10...
  assign e12 = (ilow[31] == ihigh[31]);
  assign e3  = ilow[30] & !ihigh[30];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tot_cfg    <= 16'd1;
      ilow       <= '0;
      ihigh      <= '1;
      pend       <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        tot_cfg <= total_count;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            sym_bad <= !sym_ok;
            case (func)
              FUNC_ENCODE: state <= S_READ;
              FUNC_FINISH: begin
                emit_fin <= 1'b1;
                state    <= S_EMIT;
              end
              default: ;
            endcase
          end
        end

        S_READ: begin
          cl      <= cl_c;
          ch      <= ch_c;
          tot     <= tot_eff;
          range_r <= RANGE_W'({1'b0, ihigh} - {1'b0, ilow}) + RANGE_W'(1);
          if (sym_bad || (cl_c >= ch_c)) begin
            emit_fin <= 1'b0;
            state    <= S_EMIT;
          end else begin
            state <= S_MUL_LO;
          end
        end

        S_MUL_LO: state <= S_DIV_LO;

        S_DIV_LO: begin
          if (drsp.done) begin
            ql    <= drsp.quotient;
            state <= S_MUL_HI;
          end
        end

        S_MUL_HI: state <= S_DIV_HI;

        S_DIV_HI: begin
          if (drsp.done) begin
            if (drsp.quotient == ql) begin
              // narrowed interval is empty
              emit_fin <= 1'b0;
              state    <= S_EMIT;
            end else begin
              ilow   <= nl[31:0];
              ihigh  <= nh_m1[31:0];
              shifts <= '0;
              state  <= S_SHIFT;
            end
          end
        end

        S_SHIFT: begin
          if ((shifts == 6'd32) || !(e12 || e3)) begin
            // flush the held bit as the last beat of this item
            if (!hold_valid) begin
              state <= S_IDLE;
            end else if (slot_free) begin
              out_valid    <= 1'b1;
              code_bit     <= hold_bit;
              follow_count <= hold_follow;
              final_low    <= '0;
              is_final     <= 1'b0;
              sym_error    <= 1'b0;
              last         <= 1'b1;
              hold_valid   <= 1'b0;
              state        <= S_IDLE;
            end
          end else if (e12) begin
            if (!hold_valid || slot_free) begin
              if (hold_valid) begin
                out_valid    <= 1'b1;
                code_bit     <= hold_bit;
                follow_count <= hold_follow;
                final_low    <= '0;
                is_final     <= 1'b0;
                sym_error    <= 1'b0;
                last         <= 1'b0;
              end
              hold_valid  <= 1'b1;
              hold_bit    <= ihigh[31];
              hold_follow <= pend;
              pend        <= '0;
              ilow        <= {ilow[30:0], 1'b0};
              ihigh       <= {ihigh[30:0], 1'b1};
              shifts      <= shifts + 6'd1;
            end
          end else begin
            // fold out the second bit, saturate the pending count
            if (pend != PEND_MAX) begin
              pend <= pend + 16'd1;
            end
            ilow   <= {1'b0, ilow[29:0], 1'b0};
            ihigh  <= {1'b1, ihigh[29:0], 1'b1};
            shifts <= shifts + 6'd1;
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            code_bit     <= 1'b0;
            last         <= 1'b1;
            is_final     <= emit_fin;
            sym_error    <= !emit_fin;
            follow_count <= emit_fin ? pend : 16'd0;
            final_low    <= emit_fin ? ilow : 32'd0;
            if (emit_fin) begin
              ilow  <= '0;
              ihigh <= '1;
              pend  <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
